// ===== rtl/core/clipped_alpha_blit_blend_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the alpha blit blender
// Clocked on i_clk, checks off while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef CLIPPED_ALPHA_BLIT_BLEND_MACROS_SVH
`define CLIPPED_ALPHA_BLIT_BLEND_MACROS_SVH

// antecedent and consequent in the same cycle
`define CABB_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent in the cycle after the antecedent
`define CABB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/cabb_pkg.sv =====
// ----------------------------------------------------------------------------
// cabb_pkg
// Shared types and constants of the alpha blit blender.
// ----------------------------------------------------------------------------
package cabb_pkg;

    typedef logic [23:0] t_rgb;
    typedef logic [2:0]  t_cfg_index;

    // configuration register indexes
    localparam t_cfg_index CFG_FRAME_WIDTH  = 3'd0;
    localparam t_cfg_index CFG_FRAME_HEIGHT = 3'd1;
    localparam t_cfg_index CFG_OFFSET_X     = 3'd2;
    localparam t_cfg_index CFG_OFFSET_Y     = 3'd3;
    localparam t_cfg_index CFG_IMAGE_WIDTH  = 3'd4;
    localparam t_cfg_index CFG_IMAGE_HEIGHT = 3'd5;

    localparam logic [7:0] ALPHA_CLEAR  = 8'h00;
    localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;
    localparam int unsigned ALPHA_SHIFT = 7;
    localparam int unsigned BLEND_SHIFT = 8;

endpackage

// ===== rtl/core/cabb_blend.sv =====
// ----------------------------------------------------------------------------
// cabb_blend
// Source-over blend of one ARGB word onto an RGB destination pixel.
// ----------------------------------------------------------------------------
module cabb_blend (
    input  logic [31:0]    i_pixel,
    input  cabb_pkg::t_rgb i_dst,
    output cabb_pkg::t_rgb o_colour
);
    import cabb_pkg::*;

    logic [7:0]         alpha;
    logic [8:0]         alpha_adj;
    logic signed [9:0]  alpha_s;
    logic [7:0]         src_ch [3];
    logic [7:0]         dst_ch [3];
    logic signed [8:0]  diff   [3];
    logic signed [18:0] prod   [3];
    t_rgb               mix;

    always_comb begin
        alpha     = i_pixel[31:24];
        // stretch 0..254 so that 128 and up reach one step further
        alpha_adj = {1'b0, alpha} + 9'(alpha >> ALPHA_SHIFT);
        alpha_s   = $signed({1'b0, alpha_adj});
        for (int c = 0; c < 3; c++) begin
            src_ch[c] = i_pixel[c*8 +: 8];
            dst_ch[c] = i_dst[c*8 +: 8];
            diff[c]   = $signed({1'b0, src_ch[c]}) - $signed({1'b0, dst_ch[c]});
            prod[c]   = alpha_s * diff[c];
            // low byte of d + (prod >>> 8)
            mix[c*8 +: 8] = dst_ch[c] + prod[c][BLEND_SHIFT +: 8];
        end
    end

    always_comb begin
        if (alpha == ALPHA_CLEAR) begin
            o_colour = i_dst;
        end else if (alpha == ALPHA_OPAQUE) begin
            o_colour = i_pixel[23:0];
        end else begin
            o_colour = mix;
        end
    end

endmodule

// ===== rtl/core/clipped_alpha_blit_blend.sv =====
// ----------------------------------------------------------------------------
// clipped_alpha_blit_blend
// Clipped ARGB source-over blit into an on-chip RGB frame store.
// ----------------------------------------------------------------------------
//  channel | handshake                  | payload
//  --------+----------------------------+--------------------------------------
//  in      | i_in_valid / o_in_stall    | i_kind i_image_start i_load_x/y i_pixel
//  out     | o_out_valid / i_out_stall  | o_out_x o_out_y o_out_colour
//  cfg     | i_cfg_valid / o_cfg_ready  | i_cfg_index i_cfg_data
//
//  One word per cycle while the output is not stalled; a visible draw reaches
//  the output through stage A (position), stage B (frame read, blend and
//  write-back) and the output register.
//  The frame memory has one read and one write port; same-address overlap of
//  neighboring words is covered by a one-entry bypass. No clearing after reset.
//  Loads and clipped draws give no output word. o_in_stall rises only when all
//  three stages hold words behind a stalled output.
// ----------------------------------------------------------------------------
module clipped_alpha_blit_blend #(
    parameter int MAX_FRAME_WIDTH  = 256,
    parameter int MAX_FRAME_HEIGHT = 256
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // input words
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic                  i_kind,
    input  logic                  i_image_start,
    input  logic [7:0]            i_load_x,
    input  logic [7:0]            i_load_y,
    input  logic [31:0]           i_pixel,
    // output words
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [7:0]            o_out_x,
    output logic [7:0]            o_out_y,
    output logic [23:0]           o_out_colour,
    // configuration
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  cabb_pkg::t_cfg_index  i_cfg_index,
    input  logic [15:0]           i_cfg_data
);
    import cabb_pkg::*;

    localparam int XW    = $clog2(MAX_FRAME_WIDTH);
    localparam int YW    = $clog2(MAX_FRAME_HEIGHT);
    localparam int DEPTH = MAX_FRAME_WIDTH * MAX_FRAME_HEIGHT;
    localparam int AW    = $clog2(DEPTH);

    // configuration
    logic [8:0]  r_frame_width;
    logic [8:0]  r_frame_height;
    logic [15:0] r_offset_x;
    logic [15:0] r_offset_y;
    logic [12:0] r_image_width;
    logic [12:0] r_image_height;

    // raster position
    logic [12:0] r_col, r_row;
    logic [12:0] n_col, n_row;

    // stage A: position resolved
    logic          r_a_valid, r_a_draw;
    logic [XW-1:0] r_a_x;
    logic [YW-1:0] r_a_y;
    logic [31:0]   r_a_pixel;

    // stage B: frame data back, blend and write
    logic          r_b_valid, r_b_draw;
    logic [XW-1:0] r_b_x;
    logic [YW-1:0] r_b_y;
    logic [AW-1:0] r_b_addr;
    logic [31:0]   r_b_pixel;
    t_rgb          r_mem_q;
    logic          r_byp_hit;
    t_rgb          r_byp_data;

    // output register
    logic          r_o_valid;
    logic [7:0]    r_o_x, r_o_y;
    t_rgb          r_o_colour;

    t_rgb          mem [DEPTH];

    logic          in_go, out_free, b_go, b_free, a_go, a_free;
    logic [12:0]   col_eff, row_eff, col_inc, row_inc;
    logic [12:0]   iw_eff, ih_eff, fw_lim, fh_lim;
    logic [16:0]   dx, dy;
    logic          vis, load_ok, enter_a, wrap_col;
    logic [XW-1:0] in_x;
    logic [YW-1:0] in_y;
    logic [AW-1:0] a_addr;
    t_rgb          dst, blend_rgb, b_res;

    assign o_cfg_ready = 1'b1;

    // ---------------- handshake chain ----------------
    assign out_free   = !r_o_valid || !i_out_stall;
    assign b_go       = r_b_valid && (!r_b_draw || out_free);
    assign b_free     = !r_b_valid || b_go;
    assign a_go       = r_a_valid && b_free;
    assign a_free     = !r_a_valid || b_free;
    assign o_in_stall = !a_free;
    assign in_go      = i_in_valid && !o_in_stall;

    // ---------------- placement and clipping ----------------
    always_comb begin
        col_eff = i_image_start ? '0 : r_col;
        row_eff = i_image_start ? '0 : r_row;
        dx      = {r_offset_x[15], r_offset_x} + {4'b0, col_eff};
        dy      = {r_offset_y[15], r_offset_y} + {4'b0, row_eff};
        fw_lim  = (13'(r_frame_width) > 13'(MAX_FRAME_WIDTH))
                ? 13'(MAX_FRAME_WIDTH) : 13'(r_frame_width);
        fh_lim  = (13'(r_frame_height) > 13'(MAX_FRAME_HEIGHT))
                ? 13'(MAX_FRAME_HEIGHT) : 13'(r_frame_height);
        vis     = !dx[16] && !dy[16]
                && (dx[15:0] < 16'(fw_lim)) && (dy[15:0] < 16'(fh_lim));
        load_ok = (13'(i_load_x) < 13'(MAX_FRAME_WIDTH))
                && (13'(i_load_y) < 13'(MAX_FRAME_HEIGHT));
        enter_a = in_go && (i_kind ? vis : load_ok);
        in_x    = i_kind ? dx[XW-1:0] : XW'(i_load_x);
        in_y    = i_kind ? dy[YW-1:0] : YW'(i_load_y);

        iw_eff   = (r_image_width == '0) ? 13'd1 : r_image_width;
        ih_eff   = (r_image_height == '0) ? 13'd1 : r_image_height;
        col_inc  = col_eff + 13'd1;
        row_inc  = row_eff + 13'd1;
        wrap_col = (col_inc >= iw_eff) || (col_inc == '0);
        if (wrap_col) begin
            n_col = '0;
            n_row = (row_inc >= ih_eff) ? '0 : row_inc;
        end else begin
            n_col = col_inc;
            n_row = row_eff;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= 9'd256;
            r_frame_height <= 9'd256;
            r_offset_x     <= '0;
            r_offset_y     <= '0;
            r_image_width  <= 13'd1;
            r_image_height <= 13'd1;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data[8:0];
                CFG_FRAME_HEIGHT: r_frame_height <= i_cfg_data[8:0];
                CFG_OFFSET_X:     r_offset_x     <= i_cfg_data;
                CFG_OFFSET_Y:     r_offset_y     <= i_cfg_data;
                CFG_IMAGE_WIDTH:  r_image_width  <= i_cfg_data[12:0];
                CFG_IMAGE_HEIGHT: r_image_height <= i_cfg_data[12:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (in_go && i_kind) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // ---------------- stage A ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (a_free) begin
            r_a_valid <= enter_a;
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_free && enter_a) begin
            r_a_draw  <= i_kind;
            r_a_x     <= in_x;
            r_a_y     <= in_y;
            r_a_pixel <= i_pixel;
        end
    end

    assign a_addr = AW'(r_a_y) * AW'(MAX_FRAME_WIDTH) + AW'(r_a_x);

    // ---------------- stage B ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (b_free) begin
            r_b_valid <= a_go;
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_go) begin
            r_b_draw   <= r_a_draw;
            r_b_x      <= r_a_x;
            r_b_y      <= r_a_y;
            r_b_addr   <= a_addr;
            r_b_pixel  <= r_a_pixel;
            // the word leaving B writes the entry this read returns stale
            r_byp_hit  <= b_go && (r_b_addr == a_addr);
            r_byp_data <= b_res;
        end
    end

    // frame store: read one, write one
    always_ff @(posedge i_clk) begin
        if (a_go) begin
            r_mem_q <= mem[a_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_go) begin
            mem[r_b_addr] <= b_res;
        end
    end

    assign dst = r_byp_hit ? r_byp_data : r_mem_q;

    cabb_blend u_blend (
        .i_pixel  (r_b_pixel),
        .i_dst    (dst),
        .o_colour (blend_rgb)
    );

    assign b_res = r_b_draw ? blend_rgb : r_b_pixel[23:0];

    // ---------------- output register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (out_free) begin
            r_o_valid <= b_go && r_b_draw;
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_go && r_b_draw) begin
            r_o_x      <= 8'(r_b_x);
            r_o_y      <= 8'(r_b_y);
            r_o_colour <= blend_rgb;
        end
    end

    assign o_out_valid  = r_o_valid;
    assign o_out_x      = r_o_x;
    assign o_out_y      = r_o_y;
    assign o_out_colour = r_o_colour;

    // ---------------- assertions ----------------
`include "clipped_alpha_blit_blend_macros.svh"

    `CABB_ASSERT_NEXT(a_draw_emits, b_go && r_b_draw, r_o_valid, "blended draw word lost")
    `CABB_ASSERT_NEXT(a_load_silent, b_go && !r_b_draw && out_free, !r_o_valid, "load gave output")
    `CABB_ASSERT_SAME(a_stall_full, o_in_stall, r_a_valid && r_b_valid, "stall with free stage")
    `CABB_ASSERT_NEXT(a_col_range, in_go && i_kind, r_col < $past(iw_eff), "column past width")

endmodule

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// tb: clipped alpha blit blender
// Loads frame pixels and draws ARGB images at many offsets, frame sizes and
// image sizes. A scoreboard tracks the frame store and raster position and
// predicts every written pixel. Both handshakes idle and stall at random.
// ----------------------------------------------------------------------------
module tb;
    import cabb_pkg::*;

    localparam int FRAME_MAX   = 256;
    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 300;
    localparam int MIN_WORDS   = 400;
    localparam int LAST_WORDS  = 40;
    localparam int REPORT_CAP  = 100;

    typedef struct packed {
        bit [7:0] x;
        bit [7:0] y;
        t_rgb     colour;
    } frame_write_t;

    class blit_blend_tracker;
        t_rgb             frame_mem [FRAME_MAX*FRAME_MAX];
        bit               loaded [FRAME_MAX*FRAME_MAX];
        bit [12:0]        col;
        bit [12:0]        row;
        bit [8:0]         frame_w = 9'd256;
        bit [8:0]         frame_h = 9'd256;
        bit signed [15:0] off_x;
        bit signed [15:0] off_y;
        bit [12:0]        img_w = 13'd1;
        bit [12:0]        img_h = 13'd1;
        frame_write_t     pending_writes [$];
        int               words_in;
        int               writes_seen;
        int               errors;

        task report(string msg);
            errors++;
            if (errors <= REPORT_CAP) $display("mismatch: %s", msg);
        endtask

        function void write_reg(t_cfg_index idx, bit [15:0] v);
            case (idx)
                CFG_FRAME_WIDTH:  frame_w = v[8:0];
                CFG_FRAME_HEIGHT: frame_h = v[8:0];
                CFG_OFFSET_X:     off_x = v;
                CFG_OFFSET_Y:     off_y = v;
                CFG_IMAGE_WIDTH:  img_w = v[12:0];
                CFG_IMAGE_HEIGHT: img_h = v[12:0];
                default: ;
            endcase
        endfunction

        // frame position of the next draw; 1 when it is inside the frame
        function bit landing(bit start, output bit [7:0] x, output bit [7:0] y);
            int fw, fh, dx, dy;
            fw = (frame_w > FRAME_MAX) ? FRAME_MAX : int'(frame_w);
            fh = (frame_h > FRAME_MAX) ? FRAME_MAX : int'(frame_h);
            dx = int'(off_x) + (start ? 0 : int'(col));
            dy = int'(off_y) + (start ? 0 : int'(row));
            x = dx[7:0];
            y = dy[7:0];
            return dx >= 0 && dy >= 0 && dx < fw && dy < fh;
        endfunction

        function bit needs_fill(bit start, output bit [7:0] x, output bit [7:0] y);
            return landing(start, x, y) && !loaded[{y, x}];
        endfunction

        function bit [7:0] mix(bit [7:0] s, bit [7:0] d, bit [8:0] a);
            int prod;
            prod = int'(a) * (int'(s) - int'(d));
            return 8'(int'(d) + (prod >>> BLEND_SHIFT));
        endfunction

        function t_rgb blend_pixel(t_rgb dst, bit [31:0] src);
            bit [8:0] a;
            t_rgb     res;
            a = src[31:24];
            if (src[31:24] == ALPHA_CLEAR) return dst;
            if (src[31:24] == ALPHA_OPAQUE) return src[23:0];
            a = a + (a >> ALPHA_SHIFT);
            for (int k = 0; k < 3; k++)
                res[8*k +: 8] = mix(src[8*k +: 8], dst[8*k +: 8], a);
            return res;
        endfunction

        function void take_word(bit kind, bit start, bit [7:0] lx, bit [7:0] ly,
                                bit [31:0] pix);
            bit [7:0] x, y;
            int       iw, ih;
            t_rgb     res;
            words_in++;
            if (!kind) begin
                frame_mem[{ly, lx}] = pix[23:0];
                loaded[{ly, lx}] = 1'b1;
                return;
            end
            if (landing(start, x, y)) begin
                res = blend_pixel(frame_mem[{y, x}], pix);
                frame_mem[{y, x}] = res;
                pending_writes.push_back('{x, y, res});
            end
            if (start) begin
                col = '0;
                row = '0;
            end
            iw = (img_w == 0) ? 1 : int'(img_w);
            ih = (img_h == 0) ? 1 : int'(img_h);
            col = col + 13'd1;
            if (int'(col) >= iw || col == 0) begin
                col = '0;
                row = row + 13'd1;
                if (int'(row) >= ih) row = '0;
            end
        endfunction

        task match_write(bit [7:0] x, bit [7:0] y, t_rgb colour);
            frame_write_t w;
            if (pending_writes.size() == 0) begin
                report($sformatf("unexpected word x=%0d y=%0d colour=%h", x, y, colour));
                return;
            end
            w = pending_writes.pop_front();
            writes_seen++;
            if (x !== w.x) report($sformatf("x got %0d want %0d", x, w.x));
            if (y !== w.y) report($sformatf("y got %0d want %0d", y, w.y));
            if (colour !== w.colour)
                report($sformatf("colour at (%0d,%0d) got %h want %h", w.x, w.y, colour,
                                 w.colour));
        endtask

        function int pending();
            return pending_writes.size();
        endfunction

        task leftovers();
            if (pending_writes.size() != 0)
                report($sformatf("%0d expected words never came", pending_writes.size()));
        endtask
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic        i_kind = 1'b0;
    logic        i_image_start = 1'b0;
    logic [7:0]  i_load_x = '0;
    logic [7:0]  i_load_y = '0;
    logic [31:0] i_pixel = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [7:0]  o_out_x;
    logic [7:0]  o_out_y;
    logic [23:0] o_out_colour;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    t_cfg_index  i_cfg_index = CFG_FRAME_WIDTH;
    logic [15:0] i_cfg_data = '0;

    blit_blend_tracker sb;
    int idle_pct = 10;
    bit quiet = 1'b0;
    bit hold_req = 1'b0;
    int hold_left = 0;
    int burst_left = 0;
    int cycle_count = 0;

    clipped_alpha_blit_blend #(
        .MAX_FRAME_WIDTH (FRAME_MAX),
        .MAX_FRAME_HEIGHT(FRAME_MAX)
    ) uut (.*);

    always #1 i_clk = ~i_clk;

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("FAIL");
        $finish;
    end

    // output side: check accepted words, then pick the stall for the next cycle
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid === 1'b1 && !i_out_stall)
            sb.match_write(o_out_x, o_out_y, o_out_colour);
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else if (hold_req) begin
            hold_req = 1'b0;
            hold_left = HOLD_CYCLES - 1;
            i_out_stall <= 1'b1;
        end else if (burst_left > 0) begin
            burst_left--;
            i_out_stall <= 1'b1;
        end else if (!quiet && $urandom_range(0, 99) < idle_pct) begin
            burst_left = $urandom_range(0, 10);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    task automatic send_word(bit kind, bit start, bit [7:0] lx, bit [7:0] ly,
                             bit [31:0] pix);
        int n;
        // no sender gaps while the output is held, so the pipeline fills up
        if (!quiet && hold_left == 0 && !hold_req && $urandom_range(0, 99) < idle_pct) begin
            n = $urandom_range(1, 11);
            i_in_valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_kind        <= kind;
        i_image_start <= start;
        i_load_x      <= lx;
        i_load_y      <= ly;
        i_pixel       <= pix;
        do @(posedge i_clk); while (o_in_stall);
        sb.take_word(kind, start, lx, ly, pix);
    endtask

    // a draw that would read a never-loaded frame entry gets a load first
    task automatic draw(bit start, bit [31:0] pix);
        bit [7:0] fx, fy;
        if (sb.needs_fill(start, fx, fy))
            send_word(1'b0, 1'($urandom), fx, fy, $urandom);
        send_word(1'b1, start, 8'($urandom), 8'($urandom), pix);
    endtask

    task automatic cfg_write(t_cfg_index idx, bit [15:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_reg(idx, data);
    endtask

    task automatic configure(int fw, int fh, int ox, int oy, int iw, int ih);
        cfg_write(CFG_FRAME_WIDTH, 16'(fw));
        cfg_write(CFG_FRAME_HEIGHT, 16'(fh));
        cfg_write(CFG_OFFSET_X, 16'(ox));
        cfg_write(CFG_OFFSET_Y, 16'(oy));
        cfg_write(CFG_IMAGE_WIDTH, 16'(iw));
        cfg_write(CFG_IMAGE_HEIGHT, 16'(ih));
        i_cfg_valid <= 1'b0;
    endtask

    // wait for the block to go idle; loads and clipped draws leave no trace
    task automatic settle();
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    function automatic bit [31:0] random_pixel();
        bit [7:0] a;
        case ($urandom_range(0, 9))
            0:       a = ALPHA_CLEAR;
            1:       a = ALPHA_OPAQUE;
            default: a = 8'($urandom);
        endcase
        return {a, 24'($urandom)};
    endfunction

    function automatic int pick_frame();
        case ($urandom_range(0, 19))
            0:       return 0;
            1:       return $urandom_range(257, 511);
            default: return $urandom_range(1, 256);
        endcase
    endfunction

    function automatic int pick_offset(int span);
        if ($urandom_range(0, 7) == 0) return int'($urandom_range(0, 65535)) - 32768;
        return int'($urandom_range(0, span + 16)) - 12;
    endfunction

    function automatic int pick_image();
        case ($urandom_range(0, 15))
            0:       return 0;
            1:       return $urandom_range(1, 4096);
            2:       return 4096;
            default: return $urandom_range(1, 24);
        endcase
    endfunction

    task automatic random_setup(bit dense);
        int fw, fh;
        if (dense) begin
            configure(256, 256, $urandom_range(0, 200), $urandom_range(0, 200),
                      $urandom_range(8, 32), $urandom_range(8, 32));
        end else begin
            fw = pick_frame();
            fh = pick_frame();
            configure(fw, fh, pick_offset(fw), pick_offset(fh), pick_image(), pick_image());
        end
    endtask

    task automatic run_words(int n);
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(0, 99) < 20)
                send_word(1'b0, 1'($urandom), 8'($urandom), 8'($urandom), $urandom);
            else
                draw((k == 0 && $urandom_range(0, 1) == 1) || $urandom_range(0, 49) == 0,
                     random_pixel());
        end
    endtask

    initial begin
        bit [7:0] alphas [12];
        int phase;
        int n;
        sb = new();
        alphas = '{8'h00, 8'h00, 8'hFF, 8'h01, 8'h80, 8'h7F,
                   8'h80, 8'hFE, 8'hFF, 8'h00, 8'h01, 8'h80};
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: field extremes, alpha corners, clipping on every side
        send_word(1'b0, 1'b1, 8'd255, 8'd255, 32'hFFFF_FFFF);
        send_word(1'b0, 1'b0, 8'd0, 8'd0, 32'h0000_0000);
        settle();
        configure(256, 256, -1, 254, 4, 3);
        for (int k = 0; k < 12; k++)
            draw(k == 0, {alphas[k], k[0] ? 24'hFF_FFFF : 24'h00_0000});
        settle();
        configure(0, 256, 0, 0, 4, 3);
        draw(1'b1, random_pixel());
        draw(1'b0, random_pixel());
        settle();
        // oversized frame, zero image size: every draw hits the same pixel
        configure(300, 511, 250, 255, 0, 0);
        repeat (3) draw(1'b0, {8'($urandom_range(1, 254)), 24'($urandom)});
        settle();
        configure(256, 256, 32767, -32768, 1, 1);
        draw(1'b1, random_pixel());

        phase = 0;
        while (sb.words_in < MIN_WORDS) begin
            settle();
            random_setup(phase % 3 == 2);
            case ($urandom_range(0, 3))
                0: idle_pct = 0;
                1: idle_pct = 5;
                2: idle_pct = 15;
                default: idle_pct = 30;
            endcase
            if (phase == 2) hold_req = 1'b1;
            run_words($urandom_range(30, 70));
            phase++;
        end

        settle();
        quiet = 1'b1;
        random_setup(1'b1);
        run_words(LAST_WORDS);
        i_in_valid <= 1'b0;

        n = 0;
        while (sb.pending() != 0 && n < 5000) begin
            @(posedge i_clk);
            n++;
        end
        repeat (10) @(posedge i_clk);
        sb.leftovers();
        if (sb.errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/cabb_pkg.sv
rtl/core/cabb_blend.sv
rtl/core/clipped_alpha_blit_blend.sv
bench/tb.sv
